@@ rtl/core/lcr_pkg.sv @@
// Shared types, codes and constants for the load cell ADC serial reader.
package lcr_pkg;

   localparam int unsigned DATA_BITS    = 24;
   localparam int unsigned SAMPLE_W     = DATA_BITS + 1;
   localparam int unsigned PULSE_W      = 5;
   localparam int unsigned WAIT_W       = 20;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned REQ_DATA_W   = 8;
   localparam int unsigned RSP_DATA_W   = 32;

   localparam logic [PULSE_W-1:0] GAIN_MIN       = 5'd25;
   localparam logic [PULSE_W-1:0] GAIN_MAX       = 5'd27;
   localparam logic [PULSE_W-1:0] GAIN_RESET     = 5'd25;
   localparam logic [WAIT_W-1:0]  TIMEOUT_RESET  = 20'd500000;
   localparam logic [PULSE_W-1:0] DATA_PULSES    = PULSE_W'(DATA_BITS);

   // register select, taken from csr_paddr[2]
   localparam logic REG_GAIN    = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_DOWN = 2'd2;
   localparam logic [1:0] OP_UP   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BUSY    = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;
   localparam logic [1:0] STATUS_DOWN    = 2'd3;

   typedef enum logic [1:0] {
      MODE_WAIT,
      MODE_IDLE,
      MODE_SHIFT,
      MODE_DOWN
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [PULSE_W-1:0]     pulse_count;
      logic [DATA_BITS-1:0]   shift_data;
      logic [WAIT_W-1:0]      wait_count;
      logic                   clock_high;
      logic                   dummy_pending;
   } state_type;

   // laid out as rsp_tdata, lowest field last
   typedef struct packed {
      logic [1:0]                 pad;
      logic                       ready_res;
      logic [1:0]                 status;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       sample_valid;
      logic                       clock_level;
   } result_type;

endpackage

@@ rtl/core/lcr_step.sv @@
// Per-tick state update and result logic of the serial reader.
module lcr_step (
   input  lcr_pkg::state_type              cur,
   input  logic                            data_in,
   input  logic [1:0]                      operation,
   input  logic [lcr_pkg::PULSE_W-1:0]     gain_pulses,
   input  logic [lcr_pkg::WAIT_W-1:0]      ready_timeout_ticks,
   output lcr_pkg::state_type              nxt,
   output lcr_pkg::result_type             res
);

   logic [lcr_pkg::PULSE_W-1:0]  total_pulses;
   logic [lcr_pkg::PULSE_W-1:0]  pulse_inc;
   logic                         last_pulse;
   logic                         timeout_hit;
   logic [lcr_pkg::SAMPLE_W-1:0] sample_ext;
   lcr_pkg::mode_type            mode_next;

   always_comb begin
      if (gain_pulses < lcr_pkg::GAIN_MIN) begin
         total_pulses = lcr_pkg::GAIN_MIN;
      end else if (gain_pulses > lcr_pkg::GAIN_MAX) begin
         total_pulses = lcr_pkg::GAIN_MAX;
      end else begin
         total_pulses = gain_pulses;
      end
   end

   assign pulse_inc   = cur.pulse_count + lcr_pkg::PULSE_W'(1);
   assign last_pulse  = (pulse_inc >= total_pulses);
   assign timeout_hit = (cur.wait_count >= ready_timeout_ticks);

   // next mode
   always_comb begin
      mode_next = cur.mode;
      if (operation == lcr_pkg::OP_UP) begin
         mode_next = lcr_pkg::MODE_WAIT;
      end else if (operation == lcr_pkg::OP_DOWN) begin
         mode_next = lcr_pkg::MODE_DOWN;
      end else begin
         case (cur.mode)
            lcr_pkg::MODE_WAIT: begin
               if (!data_in) begin
                  mode_next = lcr_pkg::MODE_SHIFT;
               end else if (timeout_hit) begin
                  mode_next = lcr_pkg::MODE_IDLE;
               end
            end
            lcr_pkg::MODE_IDLE: begin
               if (operation == lcr_pkg::OP_READ && !data_in) begin
                  mode_next = lcr_pkg::MODE_SHIFT;
               end
            end
            lcr_pkg::MODE_SHIFT: begin
               if (cur.clock_high && last_pulse) begin
                  mode_next = lcr_pkg::MODE_IDLE;
               end
            end
            default: begin
               mode_next = cur.mode;
            end
         endcase
      end
   end

   // counters, shift register and result fields
   always_comb begin
      nxt = cur;
      nxt.mode = mode_next;
      res = '0;
      if (operation == lcr_pkg::OP_UP) begin
         nxt.clock_high    = 1'b0;
         nxt.wait_count    = '0;
         nxt.dummy_pending = 1'b1;
         nxt.pulse_count   = '0;
      end else if (operation == lcr_pkg::OP_DOWN) begin
         nxt.clock_high  = 1'b1;
         nxt.pulse_count = '0;
         res.status      = lcr_pkg::STATUS_DOWN;
      end else begin
         case (cur.mode)
            lcr_pkg::MODE_DOWN: begin
               nxt.clock_high = 1'b1;
               res.status     = lcr_pkg::STATUS_DOWN;
            end
            lcr_pkg::MODE_WAIT: begin
               if (operation == lcr_pkg::OP_READ) begin
                  res.status = lcr_pkg::STATUS_BUSY;
               end
               if (!data_in) begin
                  nxt.pulse_count = '0;
                  nxt.shift_data  = '0;
                  nxt.clock_high  = 1'b1;
               end else if (timeout_hit) begin
                  res.status        = lcr_pkg::STATUS_TIMEOUT;
                  nxt.dummy_pending = 1'b0;
                  nxt.wait_count    = '0;
               end else begin
                  nxt.wait_count = cur.wait_count + lcr_pkg::WAIT_W'(1);
               end
            end
            lcr_pkg::MODE_IDLE: begin
               nxt.clock_high = 1'b0;
               if (operation == lcr_pkg::OP_READ) begin
                  if (data_in) begin
                     res.status = lcr_pkg::STATUS_BUSY;
                  end else begin
                     nxt.pulse_count = '0;
                     nxt.shift_data  = '0;
                     nxt.clock_high  = 1'b1;
                  end
               end else if (!data_in) begin
                  res.ready_res = 1'b1;
               end
            end
            lcr_pkg::MODE_SHIFT: begin
               if (operation == lcr_pkg::OP_READ) begin
                  res.status = lcr_pkg::STATUS_BUSY;
               end
               if (cur.clock_high) begin
                  // falling edge: sample the data line
                  nxt.clock_high = 1'b0;
                  if (cur.pulse_count < lcr_pkg::DATA_PULSES) begin
                     nxt.shift_data = {cur.shift_data[lcr_pkg::DATA_BITS-2:0], data_in};
                  end
                  nxt.pulse_count = pulse_inc;
                  if (last_pulse) begin
                     nxt.pulse_count = '0;
                     if (cur.dummy_pending) begin
                        nxt.dummy_pending = 1'b0;
                     end else begin
                        res.sample_valid = 1'b1;
                        res.sample       = lcr_pkg::SAMPLE_W'(0) - sample_ext;
                     end
                  end
               end else begin
                  nxt.clock_high = 1'b1;
               end
            end
            default: begin
               nxt.clock_high = cur.clock_high;
            end
         endcase
      end
      res.clock_level = nxt.clock_high;
   end

   assign sample_ext = {nxt.shift_data[lcr_pkg::DATA_BITS-1], nxt.shift_data};

endmodule

@@ rtl/core/load_cell_adc_serial_reader.sv @@
// Top level of the load cell ADC serial reader: stream ports, registers, result stage.
//
// Each req transaction is one tick, half a period of the converter's serial clock.
// req_tdata carries the sampled data line and an operation (none, read, power
// down, power up). Every accepted tick yields exactly one rsp transaction with
// the clock level to drive for that tick, a sample flag and value, a status
// code and a ready flag.
// The tick's state update and result are computed in the accepting cycle and
// held in the result register. One tick can be taken every cycle; req_tready
// is high whenever the result register is empty or is being emptied, so a
// stalled rsp side stalls req after one tick.
// A read drives 25 to 27 pulses (50 to 54 ticks) set by gain_pulses; after reset
// or power up the block waits for the data line low, then makes a dummy read before
// real samples are given; a timeout first goes idle and skips the dummy read.
// Reset (synchronous, active high) returns to the waiting mode with the
// dummy read due, empties the result register and restores register
// defaults (gain 25 pulses, timeout 500000 ticks).
// Registers are written over the csr port: gain_pulses at 0x0,
// ready_timeout_ticks at 0x4.
module load_cell_adc_serial_reader (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lcr_pkg::REQ_DATA_W-1:0]     req_tdata,  // data_in, operation[1:0], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // clock_level, sample_valid, sample[24:0], status[1:0], ready_res, zero pad
   output logic [lcr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lcr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lcr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lcr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [lcr_pkg::PULSE_W-1:0] gain_ff;
   logic [lcr_pkg::WAIT_W-1:0]  timeout_ff;
   lcr_pkg::state_type          state_ff;
   lcr_pkg::state_type          state_in;
   lcr_pkg::result_type         result_ff;
   lcr_pkg::result_type         result_in;
   logic                        rsp_valid_ff;
   logic                        req_take;
   logic                        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= lcr_pkg::GAIN_RESET;
         timeout_ff <= lcr_pkg::TIMEOUT_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == lcr_pkg::REG_GAIN) begin
            gain_ff <= csr_pwdata[lcr_pkg::PULSE_W-1:0];
         end else begin
            timeout_ff <= csr_pwdata[lcr_pkg::WAIT_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == lcr_pkg::REG_TIMEOUT) begin
         csr_prdata = lcr_pkg::CSR_DATA_W'(timeout_ff);
      end else begin
         csr_prdata = lcr_pkg::CSR_DATA_W'(gain_ff);
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   lcr_step u_step (
      .cur                 (state_ff),
      .data_in             (req_tdata[0]),
      .operation           (req_tdata[2:1]),
      .gain_pulses         (gain_ff),
      .ready_timeout_ticks (timeout_ff),
      .nxt                 (state_in),
      .res                 (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= lcr_pkg::MODE_WAIT;
         state_ff.pulse_count   <= '0;
         state_ff.shift_data    <= '0;
         state_ff.wait_count    <= '0;
         state_ff.clock_high    <= 1'b0;
         state_ff.dummy_pending <= 1'b1;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff;

endmodule
